FILE: rtl/pcs_pkg.sv
// Shared types and constants for the PWM channel command sequencer.
package pcs_pkg;

  typedef enum logic [2:0] {
    CMD_SET_CHANNEL = 3'd0,
    CMD_SET_DUTY    = 3'd1,
    CMD_SET_PIN     = 3'd2,
    CMD_ALL_OFF     = 3'd3,
    CMD_INVALIDATE  = 3'd4,
    CMD_SET_FREQ    = 3'd5
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PARAM_ERR = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [7:0] REG_MODE_CTRL = 8'h00;
  localparam logic [7:0] REG_CH0       = 8'h06;
  localparam logic [7:0] REG_ALL       = 8'hFA;
  localparam logic [7:0] REG_PRESCALE  = 8'hFE;
  localparam logic [7:0] BIT_RESTART   = 8'h80;
  localparam logic [7:0] BIT_AI        = 8'h20;
  localparam logic [7:0] BIT_SLEEP     = 8'h10;
  localparam logic [4:0] HIGH_MASK     = 5'h1F;

  localparam int          FULL_COUNT = 4096;
  localparam logic [12:0] FULL       = 13'd4096;

  localparam logic [1:0] CFG_OSC   = 2'd0;
  localparam logic [1:0] CFG_ADDR  = 2'd1;
  localparam logic [1:0] CFG_READY = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  channel;
    logic [12:0] on_count;
    logic [12:0] off_count;
    logic [12:0] duty;
    logic        level;
    logic [15:0] freq_request;
    logic [7:0]  mode1_readback;
  } cmd_in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        frame_start;
    logic        frame_end;
    logic [6:0]  bus_address;
    logic        last;
    logic [1:0]  status;
    logic        skipped;
    logic [15:0] actual_freq;
  } result_t;

  // Classified job handed from front to back.
  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_FRAME5 = 2'd1,
    JOB_FREQ   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  status;
    logic        skipped;
    logic [7:0]  reg_addr;
    logic [12:0] on_val;
    logic [12:0] off_val;
    logic [15:0] freq;
    logic [7:0]  mode1;
  } job_t;

endpackage

FILE: rtl/pcs_divider.sv
// Restoring divider, one quotient bit per cycle.
module pcs_divider import pcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [26:0] num,
  input  logic [27:0] den,
  output logic        done,
  output logic [26:0] quot
);
  logic [27:0] rem;
  logic [26:0] q;
  logic [4:0]  cnt;
  logic        run;
  logic [27:0] trial;

  assign trial = {rem[26:0], q[26]};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        rem <= '0;
        q   <= num;
        cnt <= 5'd27;
      end else if (run) begin
        if (trial >= den) begin
          rem <= trial - den;
          q   <= {q[25:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[25:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/pcs_front.sv
// Command classifier and shadow table.
module pcs_front import pcs_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  cmd_in_t cmd,
  input  logic    ready_cfg,
  output job_t    job
);
  logic [12:0] sh_on  [16];
  logic [12:0] sh_off [16];
  logic        trusted;
  logic [12:0] on_v, off_v;
  logic        perr, match, prog;
  logic [3:0]  c;
  logic [12:0] d;

  assign c = cmd.channel[3:0];

  always_comb begin
    d     = (cmd.command == CMD_SET_PIN) ? (cmd.level ? FULL : 13'd0) : cmd.duty;
    on_v  = 13'd0;
    off_v = d;
    perr  = 1'b0;
    prog  = 1'b0;
    job   = '0;
    job.kind  = JOB_STATUS;
    job.freq  = cmd.freq_request;
    job.mode1 = cmd.mode1_readback;
    unique case (cmd.command)
      CMD_SET_CHANNEL: begin
        on_v  = cmd.on_count;
        off_v = cmd.off_count;
        perr  = (32'(cmd.channel) >= CHANNELS) || (cmd.on_count > FULL)
                || (cmd.off_count > FULL);
        prog  = 1'b1;
      end
      CMD_SET_DUTY, CMD_SET_PIN: begin
        if (d == 13'd0) begin
          on_v = 13'd0; off_v = FULL;
        end else if (d >= FULL) begin
          on_v = FULL; off_v = 13'd0;
        end
        perr = (d > FULL) || (32'(cmd.channel) >= CHANNELS);
        prog = 1'b1;
      end
      CMD_ALL_OFF: begin
        if (!ready_cfg) job.status = ST_NOT_READY;
        else begin
          job.kind = JOB_FRAME5; job.reg_addr = REG_ALL;
          job.on_val = 13'd0; job.off_val = FULL;
        end
      end
      CMD_INVALIDATE: job.status = ST_OK;
      CMD_SET_FREQ: begin
        if (!ready_cfg) job.status = ST_NOT_READY;
        else job.kind = JOB_FREQ;
      end
      default: job.status = ST_PARAM_ERR;
    endcase
    match = trusted && sh_on[c] == on_v && sh_off[c] == off_v;
    if (prog) begin
      if (perr) job.status = ST_PARAM_ERR;
      else if (!ready_cfg) job.status = ST_NOT_READY;
      else if (match) job.skipped = 1'b1;
      else begin
        job.kind = JOB_FRAME5;
        job.reg_addr = REG_CH0 + {2'd0, c, 2'd0};
        job.on_val = on_v; job.off_val = off_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trusted <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        sh_on[i]  <= '0;
        sh_off[i] <= '0;
      end
    end else if (take) begin
      if (prog && !perr && ready_cfg && !match) begin
        sh_on[c]  <= on_v;
        sh_off[c] <= off_v;
      end
      if (cmd.command == CMD_ALL_OFF && ready_cfg) begin
        trusted <= 1'b1;
        for (int i = 0; i < 16; i++) begin
          sh_on[i]  <= '0;
          sh_off[i] <= FULL;
        end
      end
      if (cmd.command == CMD_INVALIDATE) trusted <= 1'b0;
    end
  end
endmodule

FILE: rtl/pcs_back.sv
// Frame emitter with prescale computation.
module pcs_back import pcs_pkg::*; #(
  parameter int PRESCALE_LOW  = 3,
  parameter int PRESCALE_HIGH = 255,
  parameter int FREQ_LOW      = 24,
  parameter int FREQ_HIGH     = 1526
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job_in,
  output logic        job_pop,
  input  logic [25:0] osc,
  input  logic [6:0]  addr,
  output logic        strobe,
  output result_t     res
);
  typedef enum logic [2:0] {S_IDLE, S_DIV1, S_DIV2, S_EMIT} state_t;
  state_t      state;
  job_t        job;
  logic [2:0]  idx;
  logic [15:0] achieved;
  logic [7:0]  pre;
  logic        dgo, ddone;
  logic [27:0] dden;
  logic [26:0] dq;
  logic [15:0] fclamp;
  logic [7:0]  old;
  logic [7:0]  byte_v;
  logic        fs, fe, lst;
  logic [26:0] r1;

  assign job_pop = (state == S_IDLE) && job_valid;

  pcs_divider u_div (
    .clk(clk), .rst(rst), .go(dgo), .num({1'b0, osc} + 27'(dden >> 1)),
    .den(dden), .done(ddone), .quot(dq)
  );

  always_comb begin
    fclamp = job.freq;
    if (32'(job.freq) < FREQ_LOW) fclamp = 16'(FREQ_LOW);
    else if (32'(job.freq) > FREQ_HIGH) fclamp = 16'(FREQ_HIGH);
    dden = (state == S_DIV2) ? {8'd0, pre + 8'd1, 12'd0} : {fclamp, 12'd0};
    if (state == S_DIV2 && pre == 8'hFF) dden = 28'h100000;
    r1 = (dq == 27'd0) ? 27'd0 : dq - 27'd1;
    old = job.mode1 & ~BIT_RESTART;
    byte_v = 8'd0; fs = 1'b0; fe = 1'b0; lst = 1'b0;
    if (job.kind == JOB_FRAME5) begin
      fs = (idx == 3'd0); fe = (idx == 3'd4); lst = fe;
      case (idx)
        3'd0: byte_v = job.reg_addr;
        3'd1: byte_v = job.on_val[7:0];
        3'd2: byte_v = {3'd0, job.on_val[12:8] & HIGH_MASK};
        3'd3: byte_v = job.off_val[7:0];
        default: byte_v = {3'd0, job.off_val[12:8] & HIGH_MASK};
      endcase
    end else begin
      fs = !idx[0]; fe = idx[0]; lst = (idx == 3'd7);
      case (idx)
        3'd1: byte_v = old | BIT_SLEEP;
        3'd2: byte_v = REG_PRESCALE;
        3'd3: byte_v = pre;
        3'd5: byte_v = old;
        3'd7: byte_v = old | BIT_RESTART | BIT_AI;
        default: byte_v = REG_MODE_CTRL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      strobe   <= 1'b0;
      achieved <= '0;
      dgo      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      dgo    <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid) begin
          job <= job_in;
          idx <= 3'd0;
          if (job_in.kind == JOB_STATUS) begin
            strobe <= 1'b1;
            res <= '{data_byte: 8'd0, byte_valid: 1'b0, frame_start: 1'b0,
                     frame_end: 1'b0, bus_address: addr, last: 1'b1,
                     status: job_in.status, skipped: job_in.skipped,
                     actual_freq: achieved};
          end else if (job_in.kind == JOB_FREQ) begin
            state <= S_DIV1; dgo <= 1'b1;
          end else state <= S_EMIT;
        end
        S_DIV1: if (ddone) begin
          if (r1 < 27'(PRESCALE_LOW)) pre <= 8'(PRESCALE_LOW);
          else if (r1 > 27'(PRESCALE_HIGH)) pre <= 8'(PRESCALE_HIGH);
          else pre <= r1[7:0];
          state <= S_DIV2; dgo <= 1'b1;
        end
        S_DIV2: if (ddone) begin
          achieved <= dq[15:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          res <= '{data_byte: byte_v, byte_valid: 1'b1, frame_start: fs,
                   frame_end: fe, bus_address: addr, last: lst,
                   status: ST_OK, skipped: 1'b0, actual_freq: achieved};
          idx <= idx + 3'd1;
          if (lst) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/pwm_channel_command_sequencer_unit.sv
// Top level: front classifier, two-entry job queue, back frame emitter.
// Flow: a taken start is registered into the job queue, and the emitter registers a
// status-only result onto the ports; a frame job instead enters the emit state, which
// then puts out one byte per cycle. Set-frequency runs two serial 27-bit divisions
// before its first byte, and holds the emitter until its last frame byte.
// Throughput: one command per result burst; busy holds while the queue is full.
// Reset: synchronous, clears shadow trust and table, achieved frequency, queue, registers.
// Results appear for one cycle on strobe; the receiver cannot stall them.
module pwm_channel_command_sequencer_unit import pcs_pkg::*; #(
  parameter int CHANNELS      = 16,
  parameter int PRESCALE_LOW  = 3,
  parameter int PRESCALE_HIGH = 255,
  parameter int FREQ_LOW      = 24,
  parameter int FREQ_HIGH     = 1526
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_in_t     cmd,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data,
  output logic        strobe,
  output result_t     result
);
  logic [25:0] osc;
  logic [6:0]  addr;
  logic        ready_cfg;
  logic        take, pop;
  job_t        fjob;
  job_t        q [2];
  logic [1:0]  cnt;
  logic        rd, wr;

  // Hold configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      osc <= 26'd25000000; addr <= 7'd64; ready_cfg <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OSC:   osc <= cfg_data;
        CFG_ADDR:  addr <= cfg_data[6:0];
        CFG_READY: ready_cfg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = (cnt == 2'd2);
  assign take = start && !busy;

  pcs_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst(rst), .take(take), .cmd(cmd), .ready_cfg(ready_cfg), .job(fjob)
  );

  // Two-entry job queue between classifier and emitter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; wr <= 1'b0;
    end else begin
      if (take) begin
        q[wr] <= fjob; wr <= ~wr;
      end
      if (pop) rd <= ~rd;
      cnt <= cnt + {1'b0, take} - {1'b0, pop};
    end
  end

  pcs_back #(
    .PRESCALE_LOW(PRESCALE_LOW), .PRESCALE_HIGH(PRESCALE_HIGH),
    .FREQ_LOW(FREQ_LOW), .FREQ_HIGH(FREQ_HIGH)
  ) u_back (
    .clk(clk), .rst(rst), .job_valid(cnt != 2'd0), .job_in(q[rd]), .job_pop(pop),
    .osc(osc), .addr(addr), .strobe(strobe), .res(result)
  );
endmodule
